FILE: src/ccsp_pkg.sv
// Shared widths, constants, codes and control types of the cadence, speed and power unit.
package ccsp_pkg;

    localparam int LEN_W      = 5;
    localparam int FLAGS_W    = 8;
    localparam int REVS_W     = 32;
    localparam int CREVS_W    = 16;
    localparam int TIME_W     = 16;
    localparam int CAD_W      = 8;
    localparam int SPD_W      = 14;
    localparam int PWR_W      = 10;
    localparam int RES_W      = 8;
    localparam int CIRC_W     = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam int MULB_W  = 16;
    localparam int PROD_W  = REVS_W + MULB_W;
    localparam int LIMK_W  = 18;
    localparam int LIM_W   = TIME_W + LIMK_W;
    localparam int NUM_W   = 58;
    localparam int P9_W    = PROD_W + 4;
    localparam int RNUM_W  = 34;
    localparam int PMUL_W  = RNUM_W + RES_W;
    localparam int DIVD_W  = 44;
    localparam int DVSR_W  = 29;
    localparam int QUO_W   = 16;
    localparam int CNT_W   = $clog2(QUO_W);

    localparam logic [MULB_W-1:0] MUL_CRANK  = 16'd61440;
    localparam logic [LIMK_W-1:0] LIM_CRANK  = 18'd200;
    localparam logic [LIMK_W-1:0] LIM_WHEEL  = 18'd250000;
    localparam logic [DVSR_W-1:0] SPD_DIV    = 29'd25;
    localparam logic [DVSR_W-1:0] PWR_DIV    = 29'd5000;
    localparam logic [QUO_W-1:0]  PWR_MAX    = 16'd1000;

    localparam logic [LEN_W-1:0] CRANK_MIN_LEN = 5'd5;
    localparam logic [LEN_W-1:0] WHEEL_MIN_LEN = 5'd7;
    localparam int FLAG_WHEEL = 0;
    localparam int FLAG_CRANK = 1;

    localparam logic MODE_CRANK = 1'b0;
    localparam logic MODE_WHEEL = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_RESISTANCE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCUMF    = 1'd1;

    localparam logic [RES_W-1:0]  RES_RST  = 8'd20;
    localparam logic [CIRC_W-1:0] CIRC_RST = 12'd2096;
    localparam logic [CAD_W-1:0]  CAD_RST  = 8'd80;
    localparam logic [SPD_W-1:0]  SPD_RST  = 14'd2000;
    localparam logic [PWR_W-1:0]  PWR_RST  = 10'd200;

    localparam logic [1:0] DIV_SEL_CRANK = 2'd0;
    localparam logic [1:0] DIV_SEL_SPEED = 2'd1;
    localparam logic [1:0] DIV_SEL_POWER = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       mul1;
        logic       mul2;
        logic       div_load;
        logic [1:0] div_sel;
        logic       div_step;
        logic       pmul;
        logic       store_cad;
        logic       store_spd;
        logic       store_pwr;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic mode;
        logic in_range;
        logic out_free;
    } dp_sts_t;

endpackage

FILE: src/ccsp_report_if.sv
// Report channel: one sensor report per transfer.
interface ccsp_report_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [ccsp_pkg::LEN_W-1:0]   report_length;
    logic [ccsp_pkg::FLAGS_W-1:0] report_flags;
    logic [ccsp_pkg::REVS_W-1:0]  revolutions;
    logic [ccsp_pkg::TIME_W-1:0]  event_time;

    modport source (output valid, mode, report_length, report_flags, revolutions, event_time,
                    input ready);
    modport sink   (input valid, mode, report_length, report_flags, revolutions, event_time,
                    output ready);
endinterface

FILE: src/ccsp_result_if.sv
// Result channel: current cadence, speed and power per transfer.
interface ccsp_result_if;
    logic                      valid;
    logic                      ready;
    logic                      updated;
    logic [ccsp_pkg::CAD_W-1:0] cadence_rpm;
    logic [ccsp_pkg::SPD_W-1:0] speed_centi_kmh;
    logic [ccsp_pkg::PWR_W-1:0] power_watts;

    modport source (output valid, updated, cadence_rpm, speed_centi_kmh, power_watts,
                    input ready);
    modport sink   (input valid, updated, cadence_rpm, speed_centi_kmh, power_watts,
                    output ready);
endinterface

FILE: src/ccsp_cfg_if.sv
// Configuration write channel: register index and write data.
interface ccsp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ccsp_pkg::CFG_IDX_W-1:0]  index;
    logic [ccsp_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/ccsp_ctrl.sv
// Sequencing controller for the cadence, speed and power datapath.
module ccsp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ccsp_pkg::dp_sts_t sts,
    output ccsp_pkg::dp_cmd_t cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MUL1      = 4'd1;
    localparam logic [3:0] S_MUL2      = 4'd2;
    localparam logic [3:0] S_CHECK     = 4'd3;
    localparam logic [3:0] S_DIV_CRK   = 4'd4;
    localparam logic [3:0] S_STORE_CAD = 4'd5;
    localparam logic [3:0] S_DIV_SPD   = 4'd6;
    localparam logic [3:0] S_STORE_SPD = 4'd7;
    localparam logic [3:0] S_DIV_PWR   = 4'd8;
    localparam logic [3:0] S_STORE_PWR = 4'd9;
    localparam logic [3:0] S_OUT       = 4'd10;

    localparam logic [ccsp_pkg::CNT_W-1:0] CNT_LAST = ccsp_pkg::CNT_W'(ccsp_pkg::QUO_W - 1);

    logic [3:0]                   state_reg, state_next;
    logic [ccsp_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                         cnt_last;

    assign cnt_last = (cnt_reg == CNT_LAST);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_MUL1;
                end
            end
            S_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cnt_next = '0;
                priority if (!sts.in_range)
                begin
                    state_next = S_OUT;
                end
                else if (sts.mode == ccsp_pkg::MODE_WHEEL)
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = ccsp_pkg::DIV_SEL_SPEED;
                    cmd.pmul     = 1'b1;
                    state_next   = S_DIV_SPD;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_sel  = ccsp_pkg::DIV_SEL_CRANK;
                    state_next   = S_DIV_CRK;
                end
            end
            S_DIV_CRK, S_DIV_SPD, S_DIV_PWR:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_last)
                begin
                    cnt_next = '0;
                    unique case (state_reg)
                        S_DIV_CRK: state_next = S_STORE_CAD;
                        S_DIV_SPD: state_next = S_STORE_SPD;
                        default:   state_next = S_STORE_PWR;
                    endcase
                end
            end
            S_STORE_CAD:
            begin
                cmd.store_cad = 1'b1;
                state_next    = S_OUT;
            end
            S_STORE_SPD:
            begin
                cmd.store_spd = 1'b1;
                cmd.div_load  = 1'b1;
                cmd.div_sel   = ccsp_pkg::DIV_SEL_POWER;
                state_next    = S_DIV_PWR;
            end
            S_STORE_PWR:
            begin
                cmd.store_pwr = 1'b1;
                state_next    = S_OUT;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

FILE: src/ccsp_datapath.sv
// Datapath: sensor history, multipliers, shared restoring divider and result register.
module ccsp_datapath
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         mode,
    input  logic [ccsp_pkg::LEN_W-1:0]   report_length,
    input  logic [ccsp_pkg::FLAGS_W-1:0] report_flags,
    input  logic [ccsp_pkg::REVS_W-1:0]  revolutions,
    input  logic [ccsp_pkg::TIME_W-1:0]  event_time,
    ccsp_result_if.source                result,
    ccsp_cfg_if.sink                     cfg,
    input  ccsp_pkg::dp_cmd_t            cmd,
    output ccsp_pkg::dp_sts_t            sts
);

    logic [ccsp_pkg::RES_W-1:0]   res_reg;
    logic [ccsp_pkg::CIRC_W-1:0]  circ_reg;
    logic [ccsp_pkg::CREVS_W-1:0] prev_crank_revs_reg;
    logic [ccsp_pkg::TIME_W-1:0]  prev_crank_time_reg;
    logic [ccsp_pkg::REVS_W-1:0]  prev_wheel_revs_reg;
    logic [ccsp_pkg::TIME_W-1:0]  prev_wheel_time_reg;
    logic [ccsp_pkg::CAD_W-1:0]   cad_reg;
    logic [ccsp_pkg::SPD_W-1:0]   spd_reg;
    logic [ccsp_pkg::PWR_W-1:0]   pwr_reg;
    logic                         upd_reg;
    logic                         out_valid_reg;

    logic                         mode_reg;
    logic                         calc_ok_reg;
    logic [ccsp_pkg::REVS_W-1:0]  dr_reg;
    logic [ccsp_pkg::TIME_W-1:0]  dt_reg;
    logic [ccsp_pkg::PROD_W-1:0]  prod_reg;
    logic [ccsp_pkg::LIM_W-1:0]   lim_reg;
    logic [ccsp_pkg::NUM_W-1:0]   num_reg;
    logic [ccsp_pkg::DIVD_W-1:0]  pnum_reg;
    logic [ccsp_pkg::DIVD_W-1:0]  rem_reg;
    logic [ccsp_pkg::DIVD_W-1:0]  dsh_reg;
    logic [ccsp_pkg::QUO_W-1:0]   q_reg;
    logic                         out_upd_reg;
    logic [ccsp_pkg::CAD_W-1:0]   out_cad_reg;
    logic [ccsp_pkg::SPD_W-1:0]   out_spd_reg;
    logic [ccsp_pkg::PWR_W-1:0]   out_pwr_reg;

    logic                         rep_ok;
    logic [ccsp_pkg::CREVS_W-1:0] crank_dr;
    logic [ccsp_pkg::TIME_W-1:0]  crank_dt;
    logic [ccsp_pkg::REVS_W-1:0]  wheel_dr;
    logic [ccsp_pkg::TIME_W-1:0]  wheel_dt;
    logic [ccsp_pkg::MULB_W-1:0]  mul_b;
    logic [ccsp_pkg::LIMK_W-1:0]  lim_k;
    logic [ccsp_pkg::P9_W-1:0]    prod9;
    logic [ccsp_pkg::NUM_W-1:0]   num_next;
    logic [ccsp_pkg::PMUL_W-1:0]  pm;
    logic [ccsp_pkg::DIVD_W-1:0]  pnum_next;
    logic [ccsp_pkg::DIVD_W-1:0]  dividend;
    logic [ccsp_pkg::DVSR_W-1:0]  divisor;
    logic [ccsp_pkg::DVSR_W-1:0]  dt_ext;
    logic                         rem_ge;
    logic [ccsp_pkg::DIVD_W-1:0]  rem_sub;
    logic [ccsp_pkg::PWR_W-1:0]   pwr_clamped;

    assign rep_ok = (mode == ccsp_pkg::MODE_WHEEL)
                  ? ((report_length >= ccsp_pkg::WHEEL_MIN_LEN)
                     && report_flags[ccsp_pkg::FLAG_WHEEL])
                  : ((report_length >= ccsp_pkg::CRANK_MIN_LEN)
                     && report_flags[ccsp_pkg::FLAG_CRANK]);

    assign crank_dr = revolutions[ccsp_pkg::CREVS_W-1:0] - prev_crank_revs_reg;
    assign crank_dt = event_time - prev_crank_time_reg;
    assign wheel_dr = revolutions - prev_wheel_revs_reg;
    assign wheel_dt = event_time - prev_wheel_time_reg;

    assign mul_b = (mode_reg == ccsp_pkg::MODE_WHEEL)
                 ? ccsp_pkg::MULB_W'(circ_reg) : ccsp_pkg::MUL_CRANK;
    assign lim_k = (mode_reg == ccsp_pkg::MODE_WHEEL) ? ccsp_pkg::LIM_WHEEL : ccsp_pkg::LIM_CRANK;

    // times 9216 is times nine, then shift by ten
    assign prod9 = (ccsp_pkg::P9_W'(prod_reg) << 3) + ccsp_pkg::P9_W'(prod_reg);
    assign num_next = (mode_reg == ccsp_pkg::MODE_WHEEL)
                    ? {prod9[ccsp_pkg::PROD_W-1:0], 10'b0}
                    : ccsp_pkg::NUM_W'(prod_reg);

    assign pm = num_reg[ccsp_pkg::RNUM_W-1:0] * res_reg;
    assign pnum_next = ccsp_pkg::DIVD_W'(pm) + (ccsp_pkg::DIVD_W'(pm) << 1);

    assign dt_ext = ccsp_pkg::DVSR_W'(dt_reg);

    always_comb
    begin
        unique case (cmd.div_sel)
            ccsp_pkg::DIV_SEL_CRANK:
            begin
                dividend = num_reg[ccsp_pkg::DIVD_W-1:0];
                divisor  = dt_ext;
            end
            ccsp_pkg::DIV_SEL_SPEED:
            begin
                dividend = num_reg[ccsp_pkg::DIVD_W-1:0];
                divisor  = dt_ext * ccsp_pkg::SPD_DIV;
            end
            ccsp_pkg::DIV_SEL_POWER:
            begin
                dividend = pnum_reg;
                divisor  = dt_ext * ccsp_pkg::PWR_DIV;
            end
            default:
            begin
                dividend = '0;
                divisor  = '0;
            end
        endcase
    end

    assign rem_ge  = (rem_reg >= dsh_reg);
    assign rem_sub = rem_reg - dsh_reg;

    assign pwr_clamped = (q_reg > ccsp_pkg::PWR_MAX)
                       ? ccsp_pkg::PWR_W'(ccsp_pkg::PWR_MAX) : q_reg[ccsp_pkg::PWR_W-1:0];

    assign sts.mode     = mode_reg;
    assign sts.in_range = calc_ok_reg && (num_reg <= ccsp_pkg::NUM_W'(lim_reg));
    assign sts.out_free = !out_valid_reg || result.ready;

    assign cfg.ready              = 1'b1;
    assign result.valid           = out_valid_reg;
    assign result.updated         = out_upd_reg;
    assign result.cadence_rpm     = out_cad_reg;
    assign result.speed_centi_kmh = out_spd_reg;
    assign result.power_watts     = out_pwr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg             <= ccsp_pkg::RES_RST;
            circ_reg            <= ccsp_pkg::CIRC_RST;
            prev_crank_revs_reg <= '0;
            prev_crank_time_reg <= '0;
            prev_wheel_revs_reg <= '0;
            prev_wheel_time_reg <= '0;
            cad_reg             <= ccsp_pkg::CAD_RST;
            spd_reg             <= ccsp_pkg::SPD_RST;
            pwr_reg             <= ccsp_pkg::PWR_RST;
            upd_reg             <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                unique case (cfg.index)
                    ccsp_pkg::REG_RESISTANCE: res_reg  <= cfg.data[ccsp_pkg::RES_W-1:0];
                    ccsp_pkg::REG_CIRCUMF:    circ_reg <= cfg.data[ccsp_pkg::CIRC_W-1:0];
                    default:                  res_reg  <= res_reg;
                endcase
            end
            if (cmd.capture)
            begin
                upd_reg <= 1'b0;
                if (rep_ok && (mode == ccsp_pkg::MODE_WHEEL))
                begin
                    prev_wheel_revs_reg <= revolutions;
                    prev_wheel_time_reg <= event_time;
                end
                if (rep_ok && (mode == ccsp_pkg::MODE_CRANK))
                begin
                    prev_crank_revs_reg <= revolutions[ccsp_pkg::CREVS_W-1:0];
                    prev_crank_time_reg <= event_time;
                end
            end
            if (cmd.store_cad)
            begin
                cad_reg <= q_reg[ccsp_pkg::CAD_W-1:0];
                upd_reg <= 1'b1;
            end
            if (cmd.store_spd)
            begin
                spd_reg <= q_reg[ccsp_pkg::SPD_W-1:0];
            end
            if (cmd.store_pwr)
            begin
                pwr_reg <= pwr_clamped;
                upd_reg <= 1'b1;
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= mode;
            if (mode == ccsp_pkg::MODE_WHEEL)
            begin
                dr_reg      <= wheel_dr;
                dt_reg      <= wheel_dt;
                calc_ok_reg <= rep_ok && (prev_wheel_time_reg != '0) && (wheel_dt != '0);
            end
            else
            begin
                dr_reg      <= ccsp_pkg::REVS_W'(crank_dr);
                dt_reg      <= crank_dt;
                calc_ok_reg <= rep_ok && (prev_crank_time_reg != '0) && (crank_dt != '0);
            end
        end
        if (cmd.mul1)
        begin
            prod_reg <= dr_reg * mul_b;
            lim_reg  <= dt_reg * lim_k;
        end
        if (cmd.mul2)
        begin
            num_reg <= num_next;
        end
        if (cmd.pmul)
        begin
            pnum_reg <= pnum_next;
        end
        if (cmd.div_load)
        begin
            rem_reg <= dividend;
            dsh_reg <= {divisor, {(ccsp_pkg::QUO_W - 1){1'b0}}};
            q_reg   <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_sub;
            end
            q_reg   <= {q_reg[ccsp_pkg::QUO_W-2:0], rem_ge};
            dsh_reg <= dsh_reg >> 1;
        end
        if (cmd.load_out)
        begin
            out_upd_reg <= upd_reg;
            out_cad_reg <= cad_reg;
            out_spd_reg <= spd_reg;
            out_pwr_reg <= pwr_reg;
        end
    end

endmodule

FILE: src/cycling_cadence_speed_power_calc_unit.sv
// Top level of the cycling cadence, speed and power unit.
// Each report transfer yields exactly one result transfer carrying the current cadence (rpm),
// speed (0.01 km/h) and power (W), with updated set when the report produced new values.
// One report is handled at a time: an ignored or out-of-range report goes from the range check
// straight to the result register, otherwise the shared 16-step restoring divider (one quotient
// bit per cycle) makes one pass for the cadence of a crank report, or two, for speed and power,
// for a wheel report. A new report is taken once the previous one has reached the result register,
// even if that result has not yet been transferred. Configuration writes are always taken
// and must only be issued while no report is in progress.
module cycling_cadence_speed_power_calc_unit
(
    input  logic         clk,
    input  logic         rst_n,
    ccsp_report_if.sink  report,
    ccsp_result_if.source result,
    ccsp_cfg_if.sink     cfg
);

    ccsp_pkg::dp_cmd_t cmd;
    ccsp_pkg::dp_sts_t sts;
    logic              in_ready;

    assign report.ready = in_ready;

    ccsp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (report.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ccsp_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .mode          (report.mode),
        .report_length (report.report_length),
        .report_flags  (report.report_flags),
        .revolutions   (report.revolutions),
        .event_time    (report.event_time),
        .result        (result),
        .cfg           (cfg),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

FILE: sim/ccsp_metrics_checker.sv
// Checker for the cadence, speed and power unit: predicts each result and compares it.
module ccsp_metrics_checker
(
    input  logic   clk,
    input  logic   rst_n,
    ccsp_report_if report,
    ccsp_result_if result,
    ccsp_cfg_if    cfg,
    output int     fail_count,
    output int     open_results
);
    import ccsp_pkg::*;

    localparam logic [63:0] CRANK_SCALE = 64'd61440;
    localparam logic [63:0] CAD_LIMIT   = 64'd200;
    localparam logic [63:0] WHEEL_SCALE = 64'd9216;
    localparam logic [63:0] SPD_LIMIT   = 64'd250000;
    localparam logic [63:0] SPD_DIVISOR = 64'd25;
    localparam logic [63:0] PWR_DIVISOR = 64'd5000;
    localparam logic [63:0] PWR_CAP     = 64'd1000;
    localparam int          REPORT_MAX  = 10;

    typedef struct packed {
        logic             updated;
        logic [CAD_W-1:0] cadence;
        logic [SPD_W-1:0] speed;
        logic [PWR_W-1:0] power;
    } reading_t;

    reading_t readings_due[$];

    logic [RES_W-1:0]   res_level;
    logic [CIRC_W-1:0]  circ_mm;
    logic [CREVS_W-1:0] crank_revs;
    logic [TIME_W-1:0]  crank_time;
    logic [REVS_W-1:0]  wheel_revs;
    logic [TIME_W-1:0]  wheel_time;
    logic [CAD_W-1:0]   cadence;
    logic [SPD_W-1:0]   speed;
    logic [PWR_W-1:0]   power;

    function automatic reading_t reading_after(input logic mode,
                                               input logic [LEN_W-1:0] len,
                                               input logic [FLAGS_W-1:0] flags,
                                               input logic [REVS_W-1:0] revs,
                                               input logic [TIME_W-1:0] tm);
        logic [CREVS_W-1:0] crank_step;
        logic [REVS_W-1:0]  wheel_step;
        logic [TIME_W-1:0]  span;
        logic [63:0]        num;
        logic [63:0]        watts;
        reading_t           r;
        r.updated = 1'b0;
        if (mode == MODE_CRANK)
        begin
            if (len >= CRANK_MIN_LEN && flags[FLAG_CRANK])
            begin
                crank_step = revs[CREVS_W-1:0] - crank_revs;
                span       = tm - crank_time;
                num        = 64'(crank_step) * CRANK_SCALE;
                if (crank_time != '0 && span != '0 && num <= CAD_LIMIT * 64'(span))
                begin
                    cadence   = CAD_W'(num / 64'(span));
                    r.updated = 1'b1;
                end
                crank_revs = revs[CREVS_W-1:0];
                crank_time = tm;
            end
        end
        else if (len >= WHEEL_MIN_LEN && flags[FLAG_WHEEL])
        begin
            wheel_step = revs - wheel_revs;
            span       = tm - wheel_time;
            num        = 64'(wheel_step) * 64'(circ_mm) * WHEEL_SCALE;
            if (wheel_time != '0 && span != '0 && num <= SPD_LIMIT * 64'(span))
            begin
                watts     = num * 64'(res_level) * 64'd3 / (PWR_DIVISOR * 64'(span));
                speed     = SPD_W'(num / (SPD_DIVISOR * 64'(span)));
                power     = (watts > PWR_CAP) ? PWR_W'(PWR_CAP) : PWR_W'(watts);
                r.updated = 1'b1;
            end
            wheel_revs = revs;
            wheel_time = tm;
        end
        r.cadence = cadence;
        r.speed   = speed;
        r.power   = power;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        reading_t due;
        if (!rst_n)
        begin
            res_level    = 8'd20;
            circ_mm      = 12'd2096;
            crank_revs   = '0;
            crank_time   = '0;
            wheel_revs   = '0;
            wheel_time   = '0;
            cadence      = 8'd80;
            speed        = 14'd2000;
            power        = 10'd200;
            fail_count   = 0;
            readings_due.delete();
            open_results = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_RESISTANCE: res_level = cfg.data[RES_W-1:0];
                    REG_CIRCUMF:    circ_mm   = cfg.data[CIRC_W-1:0];
                endcase
            end
            if (result.valid && result.ready)
            begin
                if (readings_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("unexpected result transfer: upd=%0d cad=%0d spd=%0d pwr=%0d",
                                 result.updated, result.cadence_rpm, result.speed_centi_kmh,
                                 result.power_watts);
                end
                else
                begin
                    due = readings_due.pop_front();
                    if (result.updated !== due.updated || result.cadence_rpm !== due.cadence ||
                        result.speed_centi_kmh !== due.speed || result.power_watts !== due.power)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("result mismatch: expected upd=%0d cad=%0d spd=%0d pwr=%0d, got upd=%0d cad=%0d spd=%0d pwr=%0d",
                                     due.updated, due.cadence, due.speed, due.power,
                                     result.updated, result.cadence_rpm,
                                     result.speed_centi_kmh, result.power_watts);
                    end
                end
            end
            if (report.valid && report.ready)
                readings_due.push_back(reading_after(report.mode, report.report_length,
                                                     report.report_flags, report.revolutions,
                                                     report.event_time));
            open_results = readings_due.size();
        end
    end

endmodule

FILE: sim/tb.sv
// Testbench top: drives sensor reports and register writes, and gives the verdict.
module tb;
    import ccsp_pkg::*;

    localparam int PHASES        = 8;
    localparam int RANDOM_ITEMS  = 190;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 60;
    localparam int STALL_LIMIT   = 3000;

    logic              clk = 1'b0;
    logic              rst_n;
    int                send_idle_pct;
    int                recv_stall_pct;
    logic              hold_req;
    int                fail_count;
    int                open_results;
    logic [CIRC_W-1:0] cur_circ;
    logic [REVS_W-1:0] crank_revs_sent;
    logic [TIME_W-1:0] crank_time_sent;
    logic [REVS_W-1:0] wheel_revs_sent;
    logic [TIME_W-1:0] wheel_time_sent;

    ccsp_report_if report_ch();
    ccsp_result_if result_ch();
    ccsp_cfg_if    cfg_ch();

    cycling_cadence_speed_power_calc_unit uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .report (report_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    ccsp_metrics_checker chk
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .report       (report_ch),
        .result       (result_ch),
        .cfg          (cfg_ch),
        .fail_count   (fail_count),
        .open_results (open_results)
    );

    always #5 clk = ~clk;

    task automatic send_report(input logic mode, input logic [LEN_W-1:0] len,
                               input logic [FLAGS_W-1:0] flags, input logic [REVS_W-1:0] revs,
                               input logic [TIME_W-1:0] tm);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            report_ch.valid <= 1'b0;
            @(negedge clk);
        end
        report_ch.valid         <= 1'b1;
        report_ch.mode          <= mode;
        report_ch.report_length <= len;
        report_ch.report_flags  <= flags;
        report_ch.revolutions   <= revs;
        report_ch.event_time    <= tm;
        do @(posedge clk); while (!report_ch.ready);
        if (mode == MODE_CRANK && len >= CRANK_MIN_LEN && flags[FLAG_CRANK])
        begin
            crank_revs_sent = revs;
            crank_time_sent = tm;
        end
        if (mode == MODE_WHEEL && len >= WHEEL_MIN_LEN && flags[FLAG_WHEEL])
        begin
            wheel_revs_sent = revs;
            wheel_time_sent = tm;
        end
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    initial
    begin
        logic hold_done;
        hold_done       = 1'b0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((report_ch.valid && report_ch.ready) || (result_ch.valid && result_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        logic               mode;
        logic [LEN_W-1:0]   len;
        logic [FLAGS_W-1:0] flags;
        logic [REVS_W-1:0]  revs;
        logic [REVS_W-1:0]  step;
        logic [REVS_W-1:0]  base_revs;
        logic [TIME_W-1:0]  base_time;
        logic [TIME_W-1:0]  tm;
        logic [63:0]        scale;
        logic [63:0]        lim;
        logic [63:0]        need;
        logic [RES_W-1:0]   lvl;
        logic [CIRC_W-1:0]  circ;
        int                 pick;
        int                 gap;
        int                 taken;

        rst_n                   = 1'b0;
        hold_req                = 1'b0;
        send_idle_pct           = 0;
        recv_stall_pct          = 0;
        cur_circ                = 12'd2096;
        crank_revs_sent         = '0;
        crank_time_sent         = '0;
        wheel_revs_sent         = '0;
        wheel_time_sent         = '0;
        report_ch.valid         = 1'b0;
        report_ch.mode          = MODE_CRANK;
        report_ch.report_length = '0;
        report_ch.report_flags  = '0;
        report_ch.revolutions   = '0;
        report_ch.event_time    = '0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = REG_RESISTANCE;
        cfg_ch.data             = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph > 0)
            begin
                case (ph)
                    1:       begin lvl = 8'd255; circ = 12'd4000; end
                    2:       begin lvl = 8'd0;   circ = 12'd500;  end
                    3:       begin lvl = 8'd20;  circ = 12'd2096; end
                    4:       begin lvl = 8'd255; circ = 12'd0;    end
                    5:       begin lvl = 8'd1;   circ = 12'd4095; end
                    6:
                    begin
                        lvl  = RES_W'($urandom_range(0, 255));
                        circ = CIRC_W'($urandom_range(0, 4095));
                    end
                    default:
                    begin
                        lvl  = RES_W'($urandom_range(0, 255));
                        circ = CIRC_W'($urandom_range(500, 4000));
                    end
                endcase
                put_reg(REG_RESISTANCE, CFG_DATA_W'(lvl));
                put_reg(REG_CIRCUMF, circ);
                @(negedge clk);
                cfg_ch.valid <= 1'b0;
                cur_circ = circ;
            end
            send_idle_pct  = (ph % 4 == 1) ? 72 : (ph % 4 == 3) ? 37 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 72 : (ph % 4 == 3) ? 37 : 0;

            if (ph == 0)
            begin
                send_report(MODE_CRANK, 5'd4,  8'h02, 32'd100, 16'd1000);
                send_report(MODE_CRANK, 5'd5,  8'hFD, 32'd100, 16'd1000);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'd100, 16'd1000);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'd105, 16'd2536);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'd110, 16'd4071);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'd110, 16'd4071);
                send_report(MODE_CRANK, 5'd20, 8'hFF, 32'hFFFF_00C8, 16'd65000);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'h0000_00C9, 16'd500);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'hFFFF_FFFF, 16'd1000);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'h0000_0001, 16'd3000);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'd5, 16'd0);
                send_report(MODE_CRANK, 5'd5,  8'h02, 32'd6, 16'd600);
                send_report(MODE_WHEEL, 5'd6,  8'h01, 32'd1000, 16'd100);
                send_report(MODE_WHEEL, 5'd7,  8'hFE, 32'd1000, 16'd100);
                send_report(MODE_WHEEL, 5'd20, 8'h02, 32'd1000, 16'd100);
                send_report(MODE_WHEEL, 5'd7,  8'h01, 32'd1000, 16'd100);
                send_report(MODE_WHEEL, 5'd7,  8'h01, 32'd1004, 16'd400);
                send_report(MODE_WHEEL, 5'd7,  8'h01, 32'd1004, 16'd400);
                send_report(MODE_WHEEL, 5'd7,  8'h01, 32'd1005, 16'd65535);
                send_report(MODE_WHEEL, 5'd7,  8'h01, 32'd1006, 16'd200);
                send_report(MODE_WHEEL, 5'd7,  8'h01, 32'hFFFF_FFFF, 16'd300);
                send_report(MODE_WHEEL, 5'd20, 8'hFF, 32'h0000_0001, 16'd0);
                send_report(MODE_WHEEL, 5'd7,  8'h01, 32'd3, 16'd500);
            end
            if (ph == 1)
            begin
                send_report(MODE_WHEEL, 5'd7, 8'h01, 32'h8000_0000, 16'd1000);
                send_report(MODE_WHEEL, 5'd7, 8'h01, 32'h8000_007D, 16'd19432);
                send_report(MODE_WHEEL, 5'd7, 8'h01, 32'h8000_00FA, 16'd37863);
            end

            taken = 0;
            while (taken < RANDOM_ITEMS)
            begin
                pick  = $urandom_range(0, 99);
                mode  = 1'($urandom_range(0, 1));
                len   = LEN_W'($urandom_range(0, 20));
                flags = FLAGS_W'($urandom_range(0, 255));
                revs  = $urandom;
                tm    = TIME_W'($urandom_range(0, 65535));
                if (pick < 70)
                begin
                    if (mode == MODE_CRANK)
                    begin
                        len               = LEN_W'($urandom_range(CRANK_MIN_LEN, 20));
                        flags[FLAG_CRANK] = 1'b1;
                        scale             = 64'd61440;
                        lim               = 64'd200;
                        base_revs         = crank_revs_sent;
                        base_time         = crank_time_sent;
                    end
                    else
                    begin
                        len               = LEN_W'($urandom_range(WHEEL_MIN_LEN, 20));
                        flags[FLAG_WHEEL] = 1'b1;
                        scale             = 64'(cur_circ) * 64'd9216;
                        lim               = 64'd250000;
                        base_revs         = wheel_revs_sent;
                        base_time         = wheel_time_sent;
                    end
                    case ($urandom_range(0, 9))
                        0:       step = $urandom;
                        1, 2:    step = $urandom_range(0, 500);
                        default: step = $urandom_range(0, 6);
                    endcase
                    need = (64'(step) * scale + lim - 64'd1) / lim;
                    if (need > 64'd65535)
                        need = 64'd65535;
                    case ($urandom_range(0, 5))
                        0:       gap = $urandom_range(0, 65535);
                        1:       gap = int'(need) + int'($urandom_range(0, 2)) - 1;
                        default: gap = int'(need) + int'($urandom_range(0, 3000));
                    endcase
                    if (gap < 0)
                        gap = 0;
                    if (gap > 65535)
                        gap = 65535;
                    tm = base_time + TIME_W'(gap);
                    if ($urandom_range(0, 19) == 0)
                        tm = '0;
                    if (mode == MODE_CRANK)
                        revs[CREVS_W-1:0] = base_revs[CREVS_W-1:0] + step[CREVS_W-1:0];
                    else
                        revs = base_revs + step;
                end
                else if (pick < 85)
                begin
                    if ($urandom_range(0, 1))
                        len = LEN_W'($urandom_range(0, (mode == MODE_CRANK)
                                                       ? CRANK_MIN_LEN - 1
                                                       : WHEEL_MIN_LEN - 1));
                    else
                        flags[(mode == MODE_CRANK) ? FLAG_CRANK : FLAG_WHEEL] = 1'b0;
                end
                send_report(mode, len, flags, revs, tm);
                taken++;
                if (ph == 0 && taken == 60)
                    hold_req = 1'b1;
            end
            @(negedge clk);
            report_ch.valid <= 1'b0;
            wait (open_results == 0);
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/ccsp_pkg.sv
src/ccsp_report_if.sv
src/ccsp_result_if.sv
src/ccsp_cfg_if.sv
src/ccsp_ctrl.sv
src/ccsp_datapath.sv
src/cycling_cadence_speed_power_calc_unit.sv
sim/ccsp_metrics_checker.sv
sim/tb.sv
